FILE: rtl/core/tcps_pkg.sv
// Shared types and codes for the two-class priority scheduler.
`default_nettype none
package tcps_pkg;

   localparam logic [2:0] ST_Q_URGENT  = 3'd0;
   localparam logic [2:0] ST_Q_REGULAR = 3'd1;
   localparam logic [2:0] ST_BAD_PRIO  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_S_URGENT  = 3'd4;
   localparam logic [2:0] ST_S_REGULAR = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;

   localparam logic [1:0] CSR_URGENT_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MIN_PRIORITY     = 2'd1;
   localparam logic [1:0] CSR_MAX_PRIORITY     = 2'd2;

   localparam logic       CMD_REGISTER = 1'b0;

   localparam logic [3:0] RST_URGENT_THRESHOLD = 4'd5;
   localparam logic [3:0] RST_MIN_PRIORITY     = 4'd1;
   localparam logic [3:0] RST_MAX_PRIORITY     = 4'd10;
   localparam logic [15:0] RST_NEXT_ID         = 16'd1;

   typedef struct packed {
      logic        command;
      logic [3:0]  priority_req;
      logic [15:0] patient_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] entry_id;
      logic [15:0] entry_tag;
      logic [3:0]  entry_priority;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] tag;
      logic [3:0]  prio;
   } slot_type;

   typedef struct packed {
      logic     insert;
      logic     pop;
      slot_type new_slot;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/core/tcps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcps_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/tcps_cell.sv
// One cell of the sorted urgent chain: holds one entry, shifts on insert or pop.
`default_nettype none
module tcps_cell
   import tcps_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic [CNT_W-1:0]   count,
   input  wire logic               prev_keep,
   input  wire slot_type           prev_slot,
   input  wire slot_type           next_slot,
   output      logic               keep,
   output      slot_type           slot
);

   slot_type slot_ff;
   slot_type slot_in;
   logic     occupied;

   assign occupied = CNT_W'(IDX) < count;
   // ties stay ahead of the new entry
   assign keep     = occupied && (slot_ff.prio >= ctl.new_slot.prio);

   always_comb begin
      slot_in = slot_ff;
      if (ctl.insert) begin
         if (!keep) begin
            slot_in = prev_keep ? ctl.new_slot : prev_slot;
         end
      end else if (ctl.pop) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule
`default_nettype wire

FILE: rtl/core/two_class_priority_scheduler_unit.sv
// Top level of the two-class priority scheduler: urgent cell chain plus regular FIFO.
//
// Usage:
//   Requests enter on req_word when start is high and busy is low. busy is high
//   only while reset is asserted; otherwise a request is taken every cycle.
//   Each request yields exactly one response word on rsp_word, marked by a
//   one-cycle rsp_strobe, in the cycle after acceptance (throughput
//   1 request per cycle). The receiver cannot stall; words must be taken on
//   the strobe cycle.
//   Urgent entries sit in a row of URGENT_DEPTH cells kept sorted by priority;
//   an insert or a pop shifts the whole row together. Regular entries sit in
//   a RAM FIFO whose read port is registered.
//   Configuration words arrive on the csr_ channel, always ready, and must be
//   written only while no request is in flight.
//   Reset restores the threshold to 5, the range to 1..10, empties both
//   stores and sets the next identifier to 1. No clearing pass is needed.
`default_nettype none
module two_class_priority_scheduler_unit
   import tcps_pkg::*;
#(
   parameter int URGENT_DEPTH  = 16,
   parameter int REGULAR_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output      logic       busy,
   input  wire req_type    req_word,
   output      logic       rsp_strobe,
   output      rsp_type    rsp_word,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [3:0] csr_data
);

   localparam int UCNT_W = $clog2(URGENT_DEPTH + 1);
   localparam int RCNT_W = $clog2(REGULAR_DEPTH + 1);
   localparam int RPTR_W = $clog2(REGULAR_DEPTH);
   localparam int SLOT_W = $bits(slot_type);

   logic [3:0]        threshold_ff, min_prio_ff, max_prio_ff;
   logic [UCNT_W-1:0] ucount_ff, ucount_in;
   logic [RCNT_W-1:0] rcount_ff, rcount_in;
   logic [RPTR_W-1:0] rhead_ff, rhead_in, rtail_ff, rtail_in;
   logic [15:0]       next_id_ff, next_id_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              from_fifo_ff, from_fifo_in;

   logic              accept;
   logic              csr_write;
   cell_ctl_type      ctl;
   logic              fifo_wr, fifo_rd;
   logic [SLOT_W-1:0] fifo_rd_bits;
   slot_type          fifo_rd_slot;
   logic              bad_prio, is_urgent;

   slot_type          cell_slot [URGENT_DEPTH];
   logic              cell_keep [URGENT_DEPTH];

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign bad_prio  = (req_word.priority_req < min_prio_ff) ||
                      (req_word.priority_req > max_prio_ff);
   assign is_urgent = req_word.priority_req > threshold_ff;

   always_comb begin
      ctl.insert        = 1'b0;
      ctl.pop           = 1'b0;
      ctl.new_slot.id   = next_id_ff;
      ctl.new_slot.tag  = req_word.patient_tag;
      ctl.new_slot.prio = req_word.priority_req;
      fifo_wr      = 1'b0;
      fifo_rd      = 1'b0;
      from_fifo_in = 1'b0;
      ucount_in    = ucount_ff;
      rcount_in    = rcount_ff;
      rhead_in     = rhead_ff;
      rtail_in     = rtail_ff;
      next_id_in   = next_id_ff;
      rsp_in       = '0;
      if (accept) begin
         if (req_word.command == CMD_REGISTER) begin
            if (bad_prio) begin
               rsp_in.status = ST_BAD_PRIO;
            end else if (is_urgent) begin
               if (ucount_ff >= UCNT_W'(URGENT_DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ctl.insert      = 1'b1;
                  ucount_in       = ucount_ff + UCNT_W'(1);
                  next_id_in      = next_id_ff + 16'd1;
                  rsp_in.status   = ST_Q_URGENT;
                  rsp_in.entry_id = next_id_ff;
               end
            end else begin
               if (rcount_ff >= RCNT_W'(REGULAR_DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  fifo_wr         = 1'b1;
                  rcount_in       = rcount_ff + RCNT_W'(1);
                  rtail_in        = (rtail_ff == RPTR_W'(REGULAR_DEPTH - 1)) ?
                                    '0 : rtail_ff + RPTR_W'(1);
                  next_id_in      = next_id_ff + 16'd1;
                  rsp_in.status   = ST_Q_REGULAR;
                  rsp_in.entry_id = next_id_ff;
               end
            end
         end else if (ucount_ff != '0) begin
            ctl.pop               = 1'b1;
            ucount_in             = ucount_ff - UCNT_W'(1);
            rsp_in.status         = ST_S_URGENT;
            rsp_in.entry_id       = cell_slot[0].id;
            rsp_in.entry_tag      = cell_slot[0].tag;
            rsp_in.entry_priority = cell_slot[0].prio;
         end else if (rcount_ff != '0) begin
            fifo_rd       = 1'b1;
            from_fifo_in  = 1'b1;
            rcount_in     = rcount_ff - RCNT_W'(1);
            rhead_in      = (rhead_ff == RPTR_W'(REGULAR_DEPTH - 1)) ?
                            '0 : rhead_ff + RPTR_W'(1);
            rsp_in.status = ST_S_REGULAR;
         end else begin
            rsp_in.status = ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RST_URGENT_THRESHOLD;
         min_prio_ff  <= RST_MIN_PRIORITY;
         max_prio_ff  <= RST_MAX_PRIORITY;
         ucount_ff    <= '0;
         rcount_ff    <= '0;
         rhead_ff     <= '0;
         rtail_ff     <= '0;
         next_id_ff   <= RST_NEXT_ID;
         rsp_valid_ff <= 1'b0;
         from_fifo_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_URGENT_THRESHOLD: threshold_ff <= csr_data;
               CSR_MIN_PRIORITY:     min_prio_ff  <= csr_data;
               CSR_MAX_PRIORITY:     max_prio_ff  <= csr_data;
               default: ;
            endcase
         end
         ucount_ff    <= ucount_in;
         rcount_ff    <= rcount_in;
         rhead_ff     <= rhead_in;
         rtail_ff     <= rtail_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= accept;
         from_fifo_ff <= from_fifo_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   for (genvar i = 0; i < URGENT_DEPTH; i++) begin : g_cell
      logic     prev_keep;
      slot_type prev_slot;
      slot_type next_slot;
      if (i == 0) begin : g_first
         assign prev_keep = 1'b1;
         assign prev_slot = ctl.new_slot;
      end else begin : g_mid
         assign prev_keep = cell_keep[i-1];
         assign prev_slot = cell_slot[i-1];
      end
      if (i == URGENT_DEPTH - 1) begin : g_last
         assign next_slot = cell_slot[i];
      end else begin : g_inner
         assign next_slot = cell_slot[i+1];
      end
      tcps_cell #(
         .IDX   (i),
         .CNT_W (UCNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (ucount_ff),
         .prev_keep (prev_keep),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .keep      (cell_keep[i]),
         .slot      (cell_slot[i])
      );
   end

   tcps_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (REGULAR_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_wr),
      .wr_addr (rtail_ff),
      .wr_data (ctl.new_slot),
      .rd_en   (fifo_rd),
      .rd_addr (rhead_ff),
      .rd_data (fifo_rd_bits)
   );

   assign fifo_rd_slot = slot_type'(fifo_rd_bits);

   always_comb begin
      rsp_word = rsp_ff;
      if (from_fifo_ff) begin
         rsp_word.entry_id       = fifo_rd_slot.id;
         rsp_word.entry_tag      = fifo_rd_slot.tag;
         rsp_word.entry_priority = fifo_rd_slot.prio;
      end
   end

   assign rsp_strobe = rsp_valid_ff;

`ifndef SYNTHESIS
   a_ucount_bound: assert property (@(posedge clock) disable iff (reset)
      ucount_ff <= UCNT_W'(URGENT_DEPTH))
      else $error("urgent count above depth");

   a_rcount_bound: assert property (@(posedge clock) disable iff (reset)
      rcount_ff <= RCNT_W'(REGULAR_DEPTH))
      else $error("regular count above depth");

   a_one_word_per_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request without response word");

   a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
      (ucount_ff >= UCNT_W'(2)) |-> (cell_slot[0].prio >= cell_slot[1].prio))
      else $error("urgent chain head out of order");

   a_fifo_serve_nonempty: assert property (@(posedge clock) disable iff (reset)
      fifo_rd |-> (ucount_ff == '0) && (rcount_ff != '0))
      else $error("fifo read while urgent pending or fifo empty");
`endif

endmodule
`default_nettype wire

FILE: sim/tcps_order_checker.sv
// Watches the scheduler's request, response and CSR channels and checks each response word.
module tcps_order_checker
   import tcps_pkg::*;
#(
   parameter int URGENT_SLOTS  = 16,
   parameter int REGULAR_SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_word,
   input  logic       rsp_strobe,
   input  rsp_type    rsp_word,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data,
   output int         failures,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [3:0]  threshold;
   logic [3:0]  min_prio;
   logic [3:0]  max_prio;
   slot_type    urgent_row[URGENT_SLOTS];
   int          urgent_fill;
   slot_type    regular_ring[REGULAR_SLOTS];
   int          ring_head;
   int          ring_tail;
   int          regular_fill;
   logic [15:0] ticket;
   rsp_type     outcome_q[$];
   int          fail_tally = 0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
         fail_tally++;
      end
   endtask

   // Applies one request to the local copy of both stores and returns its response word.
   task automatic schedule_request(input req_type w, output rsp_type r);
      slot_type s;
      bit       urgent;
      int       pos;
      r = '0;
      if (w.command == CMD_REGISTER) begin
         if (w.priority_req < min_prio || w.priority_req > max_prio) begin
            r.status = ST_BAD_PRIO;
         end else begin
            urgent = w.priority_req > threshold;
            if (urgent ? (urgent_fill >= URGENT_SLOTS) : (regular_fill >= REGULAR_SLOTS)) begin
               r.status = ST_FULL;
            end else begin
               s.id   = ticket;
               s.tag  = w.patient_tag;
               s.prio = w.priority_req;
               if (urgent) begin
                  // stable: a new entry goes behind all entries of equal priority
                  pos = 0;
                  while (pos < urgent_fill && urgent_row[pos].prio >= s.prio)
                     pos++;
                  for (int i = urgent_fill; i > pos; i--)
                     urgent_row[i] = urgent_row[i - 1];
                  urgent_row[pos] = s;
                  urgent_fill++;
                  r.status = ST_Q_URGENT;
               end else begin
                  regular_ring[ring_tail] = s;
                  ring_tail = (ring_tail + 1) % REGULAR_SLOTS;
                  regular_fill++;
                  r.status = ST_Q_REGULAR;
               end
               r.entry_id = ticket;
               ticket++;
            end
         end
      end else if (urgent_fill > 0) begin
         s = urgent_row[0];
         for (int i = 1; i < urgent_fill; i++)
            urgent_row[i - 1] = urgent_row[i];
         urgent_fill--;
         r.status         = ST_S_URGENT;
         r.entry_id       = s.id;
         r.entry_tag      = s.tag;
         r.entry_priority = s.prio;
      end else if (regular_fill > 0) begin
         s = regular_ring[ring_head];
         ring_head = (ring_head + 1) % REGULAR_SLOTS;
         regular_fill--;
         r.status         = ST_S_REGULAR;
         r.entry_id       = s.id;
         r.entry_tag      = s.tag;
         r.entry_priority = s.prio;
      end else begin
         r.status = ST_EMPTY;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         threshold    = RST_URGENT_THRESHOLD;
         min_prio     = RST_MIN_PRIORITY;
         max_prio     = RST_MAX_PRIORITY;
         urgent_fill  = 0;
         ring_head    = 0;
         ring_tail    = 0;
         regular_fill = 0;
         ticket       = RST_NEXT_ID;
         outcome_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: response word with none expected: expected none, got %h",
                        $time, rsp_word);
               fail_tally++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_word.status));
               check_field("entry_id", want.entry_id, rsp_word.entry_id);
               check_field("entry_tag", want.entry_tag, rsp_word.entry_tag);
               check_field("entry_priority", 16'(want.entry_priority),
                           16'(rsp_word.entry_priority));
            end
         end
         if (start && !busy) begin
            schedule_request(req_word, want);
            outcome_q.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_URGENT_THRESHOLD: threshold = csr_data;
               CSR_MIN_PRIORITY:     min_prio  = csr_data;
               CSR_MAX_PRIORITY:     max_prio  = csr_data;
               default: ;
            endcase
         end
      end
      pending  <= outcome_q.size();
      failures <= fail_tally;
   end

endmodule

FILE: sim/tb_top.sv
// Stimulus and verdict for the two-class priority scheduler.
module tb_top;
   import tcps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  URGENT_SLOTS  = 16;
   localparam int  REGULAR_SLOTS = 16;
   localparam logic CMD_SERVE    = ~CMD_REGISTER;

   localparam logic [3:0] THR_SET [6] = '{4'd0, 4'd15, 4'd7, 4'd15, 4'd0, 4'd9};
   localparam logic [3:0] MIN_SET [6] = '{4'd0, 4'd0, 4'd3, 4'd15, 4'd15, 4'd2};
   localparam logic [3:0] MAX_SET [6] = '{4'd15, 4'd15, 4'd12, 4'd15, 4'd0, 4'd14};

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   logic       busy;
   req_type    req_word  = '0;
   logic       rsp_strobe;
   rsp_type    rsp_word;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_URGENT_THRESHOLD;
   logic [3:0] csr_data  = '0;
   int         failures;
   int         pending;

   logic [3:0] cur_thr = RST_URGENT_THRESHOLD;
   logic [3:0] cur_min = RST_MIN_PRIORITY;
   logic [3:0] cur_max = RST_MAX_PRIORITY;
   int         quiet_run = 0;

   two_class_priority_scheduler_unit #(
      .URGENT_DEPTH (URGENT_SLOTS),
      .REGULAR_DEPTH(REGULAR_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tcps_order_checker #(
      .URGENT_SLOTS (URGENT_SLOTS),
      .REGULAR_SLOTS(REGULAR_SLOTS)
   ) sched_check (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // idle cycles before the next word; some stretches run back to back
   function automatic int draw_gap();
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_run = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // start stays high after the handshake so back-to-back words need no toggle
   task automatic send_word(input logic cmd, input logic [3:0] prio,
                            input logic [15:0] tag, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_word.command      <= cmd;
      req_word.priority_req <= prio;
      req_word.patient_tag  <= tag;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [3:0] thr, input logic [3:0] lo,
                                input logic [3:0] hi);
      settle();
      write_csr(CSR_URGENT_THRESHOLD, thr);
      write_csr(CSR_MIN_PRIORITY, lo);
      write_csr(CSR_MAX_PRIORITY, hi);
      csr_valid <= 1'b0;
      cur_thr = thr;
      cur_min = lo;
      cur_max = hi;
   endtask

   task automatic run_phase(input int items, input int reg_pct);
      logic       cmd;
      logic [3:0] prio;
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 59) == 0)
            settle();
         cmd  = ($urandom_range(0, 99) < reg_pct) ? CMD_REGISTER : CMD_SERVE;
         prio = 4'($urandom_range(0, 15));
         if (cmd == CMD_REGISTER && cur_min <= cur_max && $urandom_range(0, 99) < 85)
            prio = 4'($urandom_range(cur_min, cur_max));
         send_word(cmd, prio, 16'($urandom), draw_gap());
      end
   endtask

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: range 1..10, urgent above 5
      send_word(CMD_SERVE, 4'hF, 16'hFFFF, draw_gap());
      send_word(CMD_REGISTER, 4'd0, 16'h1234, draw_gap());
      send_word(CMD_REGISTER, 4'd15, 16'hEDCB, draw_gap());
      send_word(CMD_REGISTER, 4'd1, 16'h0000, draw_gap());
      send_word(CMD_REGISTER, 4'd10, 16'hFFFF, draw_gap());
      send_word(CMD_REGISTER, 4'd6, 16'h5A5A, draw_gap());
      send_word(CMD_REGISTER, 4'd10, 16'h8001, draw_gap());
      send_word(CMD_REGISTER, 4'd5, 16'hA5A5, draw_gap());
      repeat (6) send_word(CMD_SERVE, 4'h0, 16'h0000, draw_gap());

      // empty range
      apply_setting(4'd5, 4'd12, 4'd3);
      send_word(CMD_REGISTER, 4'd7, 16'h0F0F, draw_gap());
      send_word(CMD_REGISTER, 4'd3, 16'hF0F0, draw_gap());
      send_word(CMD_REGISTER, 4'd12, 16'h7FFF, draw_gap());

      // both stores to full and one past, then drain past empty
      apply_setting(RST_URGENT_THRESHOLD, RST_MIN_PRIORITY, RST_MAX_PRIORITY);
      repeat (URGENT_SLOTS + 1)
         send_word(CMD_REGISTER, 4'($urandom_range(6, 10)), 16'($urandom), draw_gap());
      repeat (REGULAR_SLOTS + 1)
         send_word(CMD_REGISTER, 4'($urandom_range(1, 5)), 16'($urandom), draw_gap());
      repeat (URGENT_SLOTS + REGULAR_SLOTS + 2)
         send_word(CMD_SERVE, 4'($urandom), 16'($urandom), draw_gap());

      for (int p = 0; p < 6; p++) begin
         apply_setting(THR_SET[p], MIN_SET[p], MAX_SET[p]);
         run_phase(95, (p % 2 == 0) ? 70 : 40);
      end
      apply_setting(4'($urandom), 4'($urandom_range(0, 7)), 4'($urandom_range(8, 15)));
      run_phase(95, 55);

      settle();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: two_class_priority_scheduler_unit.f
rtl/core/tcps_pkg.sv
rtl/core/tcps_ram.sv
rtl/core/tcps_cell.sv
rtl/core/two_class_priority_scheduler_unit.sv
sim/tcps_order_checker.sv
sim/tb_top.sv
